/* hw/rtl/stxd_pkg.sv */
package stxd_pkg;

  // Frame layout: start marker, length lo/hi, command lo/hi, payload, end marker
  localparam int FRAME_OVERHEAD = 6;
  localparam int OFS_LEN_LO     = 1;
  localparam int OFS_LEN_HI     = 2;
  localparam int OFS_CMD_LO     = 3;
  localparam int OFS_CMD_HI     = 4;
  localparam int OFS_PAYLOAD    = 5;

  localparam logic [7:0] START_MARKER_RST = 8'h02;
  localparam logic [7:0] END_MARKER_RST   = 8'h03;

  localparam logic [0:0] REG_START_MARKER = 1'b0;
  localparam logic [0:0] REG_END_MARKER   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HUNT,
    ST_HUNT_CHK,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_TAIL_RD,
    ST_TAIL_CHK,
    ST_CMD_LO,
    ST_CMD_HI,
    ST_EMIT_RD,
    ST_EMIT_LD
  } stxd_state_t;

endpackage

/* hw/rtl/stxd_ram.sv */
module stxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/stx_etx_frame_deframer.sv */
// Input: a byte is taken only in idle; the block then hunts the store for a frame, dropping
// its first byte whenever no frame can start there, before it takes the next byte.
// A byte that completes a good frame releases its results one at a time, each waiting for
// a free output register; the next input item is taken once the last is loaded.
// Rate is set by the single-port frame store: one byte read per cycle, with a registered read.
// Reset (synchronous, rst_n low): store empty, head at 0, markers 2 and 3, no result pending.
module stx_etx_frame_deframer #(
  parameter int FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_command,
  output logic [7:0]  out_payload_byte,
  output logic        out_empty_frame,
  output logic        out_last_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam logic [FW:0]   NB      = (FW+1)'(FRAME_BYTES);
  localparam logic [FW-1:0] DEPTH_F = FW'(FRAME_BYTES);
  localparam logic [FW-1:0] OVH     = FW'(stxd_pkg::FRAME_OVERHEAD);
  localparam logic [FW-1:0] ONE     = FW'(1);
  localparam logic [15:0]   MAXLEN  = 16'(FRAME_BYTES - stxd_pkg::FRAME_OVERHEAD);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [FW-1:0] ofs);
    logic [FW:0] sum;
    sum = {{(FW+1-AW){1'b0}}, base} + {1'b0, ofs};
    if (sum >= NB) begin
      sum = sum - NB;
    end
    return sum[AW-1:0];
  endfunction

  stxd_pkg::stxd_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    len_lo_r, len_lo_nxt;
  logic [FW-1:0] len_r, len_nxt;
  logic [15:0]   cmd_r, cmd_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [7:0]    start_r, end_r;

  logic          out_valid_r;
  logic [15:0]   out_command_r;
  logic [7:0]    out_payload_byte_r;
  logic          out_empty_frame_r;
  logic          out_last_of_frame_r;

  logic          ram_we;
  logic [FW-1:0] ram_ofs;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic          in_fire;
  logic          cfg_write;
  logic          out_load;
  logic          out_last;
  logic [15:0]   len16;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= stxd_pkg::START_MARKER_RST;
      end_r   <= stxd_pkg::END_MARKER_RST;
    end else if (cfg_write) begin
      unique case (paddr[2:2])
        stxd_pkg::REG_START_MARKER: start_r <= pwdata[7:0];
        stxd_pkg::REG_END_MARKER:   end_r   <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      stxd_pkg::REG_START_MARKER: prdata = {24'd0, start_r};
      stxd_pkg::REG_END_MARKER:   prdata = {24'd0, end_r};
    endcase
  end

  // ---------------- frame store ----------------
  assign ram_addr = wrap_add(head_r, ram_ofs);

  stxd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_rx_byte),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer ----------------
  assign in_fire  = in_valid & in_ready;
  assign len16    = {ram_rdata, len_lo_r};
  assign out_last = (len_r == '0) || ((idx_r + ONE) == len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stxd_pkg::ST_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_lo_r <= len_lo_nxt;
    len_r    <= len_nxt;
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    ram_we     = 1'b0;
    ram_ofs    = '0;
    in_ready   = 1'b0;
    out_load   = 1'b0;

    unique case (state_r)
      stxd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ram_ofs  = fill_r;
        if (in_fire) begin
          // drop the byte if the store is full
          if (fill_r < DEPTH_F) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + ONE;
          end
          state_nxt = stxd_pkg::ST_HUNT;
        end
      end
      stxd_pkg::ST_HUNT: begin
        state_nxt = (fill_r == '0) ? stxd_pkg::ST_IDLE : stxd_pkg::ST_HUNT_CHK;
      end
      stxd_pkg::ST_HUNT_CHK: begin
        if (ram_rdata != start_r) begin
          head_nxt  = wrap_add(head_r, ONE);
          fill_nxt  = fill_r - ONE;
          state_nxt = stxd_pkg::ST_HUNT;
        end else if (fill_r < OVH) begin
          state_nxt = stxd_pkg::ST_IDLE;
        end else begin
          ram_ofs   = FW'(stxd_pkg::OFS_LEN_LO);
          state_nxt = stxd_pkg::ST_LEN_LO;
        end
      end
      stxd_pkg::ST_LEN_LO: begin
        len_lo_nxt = ram_rdata;
        ram_ofs    = FW'(stxd_pkg::OFS_LEN_HI);
        state_nxt  = stxd_pkg::ST_LEN_HI;
      end
      stxd_pkg::ST_LEN_HI: begin
        if (len16 > MAXLEN) begin
          head_nxt  = wrap_add(head_r, ONE);
          fill_nxt  = fill_r - ONE;
          state_nxt = stxd_pkg::ST_HUNT;
        end else if ({1'b0, fill_r} < ({1'b0, len16[FW-1:0]} + {1'b0, OVH})) begin
          state_nxt = stxd_pkg::ST_IDLE;
        end else begin
          len_nxt   = len16[FW-1:0];
          state_nxt = stxd_pkg::ST_TAIL_RD;
        end
      end
      stxd_pkg::ST_TAIL_RD: begin
        ram_ofs   = len_r + FW'(stxd_pkg::OFS_PAYLOAD);
        state_nxt = stxd_pkg::ST_TAIL_CHK;
      end
      stxd_pkg::ST_TAIL_CHK: begin
        if (ram_rdata != end_r) begin
          head_nxt  = wrap_add(head_r, ONE);
          fill_nxt  = fill_r - ONE;
          state_nxt = stxd_pkg::ST_HUNT;
        end else begin
          ram_ofs   = FW'(stxd_pkg::OFS_CMD_LO);
          state_nxt = stxd_pkg::ST_CMD_LO;
        end
      end
      stxd_pkg::ST_CMD_LO: begin
        cmd_nxt   = {cmd_r[15:8], ram_rdata};
        ram_ofs   = FW'(stxd_pkg::OFS_CMD_HI);
        state_nxt = stxd_pkg::ST_CMD_HI;
      end
      stxd_pkg::ST_CMD_HI: begin
        cmd_nxt   = {ram_rdata, cmd_r[7:0]};
        idx_nxt   = '0;
        state_nxt = stxd_pkg::ST_EMIT_RD;
      end
      stxd_pkg::ST_EMIT_RD: begin
        ram_ofs = idx_r + FW'(stxd_pkg::OFS_PAYLOAD);
        // hold until the output register is free by the next edge
        if (!out_valid_r || out_ready) begin
          state_nxt = stxd_pkg::ST_EMIT_LD;
        end
      end
      stxd_pkg::ST_EMIT_LD: begin
        out_load = 1'b1;
        if (out_last) begin
          head_nxt  = wrap_add(head_r, len_r + OVH);
          fill_nxt  = fill_r - (len_r + OVH);
          state_nxt = stxd_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + ONE;
          state_nxt = stxd_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = stxd_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_command_r       <= cmd_r;
      out_payload_byte_r  <= (len_r == '0) ? 8'd0 : ram_rdata;
      out_empty_frame_r   <= (len_r == '0);
      out_last_of_frame_r <= out_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command       = out_command_r;
  assign out_payload_byte  = out_payload_byte_r;
  assign out_empty_frame   = out_empty_frame_r;
  assign out_last_of_frame = out_last_of_frame_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F)
    else $error("store fill exceeds capacity");

  a_emit_frame_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stxd_pkg::ST_EMIT_RD || state_r == stxd_pkg::ST_EMIT_LD)
      |-> ({1'b0, fill_r} >= ({1'b0, len_r} + {1'b0, OVH})))
    else $error("emitting a frame that is not fully stored");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stxd_pkg::ST_EMIT_LD) |-> (!out_valid_r || $past(out_ready)))
    else $error("output register overwritten while an item is pending");

  a_byte_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && fill_r < DEPTH_F) |=> (fill_r == $past(fill_r) + ONE))
    else $error("accepted byte not added to the store");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last) |=> (state_r == stxd_pkg::ST_IDLE && out_valid_r))
    else $error("frame end did not return to idle");
`endif

endmodule

/* test/stx_etx_frame_deframer_tb.sv */
module stx_etx_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES      = 32;
  localparam int MAX_PAYLOAD      = STORE_BYTES - stxd_pkg::FRAME_OVERHEAD;
  localparam int SETTLE_CYCLES    = 300;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int PHASE_BYTES      = 80;
  localparam logic [2:0] ADDR_START = {stxd_pkg::REG_START_MARKER, 2'b00};
  localparam logic [2:0] ADDR_END   = {stxd_pkg::REG_END_MARKER, 2'b00};

  typedef struct packed {
    logic [15:0] command;
    logic [7:0]  payload_byte;
    logic        empty_frame;
    logic        last_of_frame;
  } delivery_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_command;
  logic [7:0]  out_payload_byte;
  logic        out_empty_frame;
  logic        out_last_of_frame;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block's store and markers
  logic [7:0]  store_mem [STORE_BYTES];
  int unsigned store_head = 0;
  int unsigned store_fill = 0;
  logic [7:0]  start_mk = stxd_pkg::START_MARKER_RST;
  logic [7:0]  end_mk = stxd_pkg::END_MARKER_RST;

  delivery_t   delivery_q[$];
  logic [7:0]  rx_byte_q[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int          err_cnt = 0;

  int          tx_gap = 0;
  bit          tx_calm = 1'b0;
  int          rx_gap = 0;
  bit          rx_calm = 1'b0;
  int unsigned long_hold_left = 0;
  bit          long_hold_arm = 1'b0;
  bit          long_hold_done = 1'b0;

  always #5 clk = ~clk;

  stx_etx_frame_deframer #(.FRAME_BYTES(STORE_BYTES)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command      (out_command),
    .out_payload_byte (out_payload_byte),
    .out_empty_frame  (out_empty_frame),
    .out_last_of_frame(out_last_of_frame),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  function automatic logic [7:0] store_at(int unsigned k);
    return store_mem[(store_head + k) % STORE_BYTES];
  endfunction

  function automatic void store_drop(int unsigned n);
    store_head = (store_head + n) % STORE_BYTES;
    store_fill -= n;
  endfunction

  // Take one received byte and queue every delivery it releases
  function automatic void deframe_byte(logic [7:0] b);
    int unsigned len;
    int unsigned i;
    logic [15:0] cmd;
    delivery_t   d;
    if (store_fill < STORE_BYTES) begin
      store_mem[(store_head + store_fill) % STORE_BYTES] = b;
      store_fill++;
    end
    while (1) begin
      while (store_fill > 0 && store_at(0) != start_mk) store_drop(1);
      if (store_fill < stxd_pkg::FRAME_OVERHEAD) return;
      len = {16'h0, store_at(stxd_pkg::OFS_LEN_HI), store_at(stxd_pkg::OFS_LEN_LO)};
      if (len > MAX_PAYLOAD) begin
        store_drop(1);
        continue;
      end
      if (store_fill < len + stxd_pkg::FRAME_OVERHEAD) return;
      if (store_at(len + stxd_pkg::FRAME_OVERHEAD - 1) != end_mk) begin
        store_drop(1);
        continue;
      end
      cmd = {store_at(stxd_pkg::OFS_CMD_HI), store_at(stxd_pkg::OFS_CMD_LO)};
      d.command = cmd;
      if (len == 0) begin
        d.payload_byte  = 8'h00;
        d.empty_frame   = 1'b1;
        d.last_of_frame = 1'b1;
        delivery_q.push_back(d);
      end else begin
        for (i = 0; i < len; i++) begin
          d.payload_byte  = store_at(stxd_pkg::OFS_PAYLOAD + i);
          d.empty_frame   = 1'b0;
          d.last_of_frame = (i + 1 == len);
          delivery_q.push_back(d);
        end
      end
      store_drop(len + stxd_pkg::FRAME_OVERHEAD);
      return;
    end
  endfunction

  function automatic void put(logic [7:0] b);
    rx_byte_q.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void put_frame(int unsigned len, logic [15:0] cmd, bit good_end);
    put(start_mk);
    put(len[7:0]);
    put(len[15:8]);
    put(cmd[7:0]);
    put(cmd[15:8]);
    repeat (len) put(8'($urandom_range(0, 255)));
    put(good_end ? end_mk : end_mk ^ 8'($urandom_range(1, 255)));
  endfunction

  // Mostly well-formed frames, mixed with bad tails, oversized lengths,
  // stray bytes, cut-off headers and frames hidden inside broken ones
  function automatic void random_traffic(int unsigned n);
    int unsigned goal;
    int unsigned kind;
    int unsigned len;
    int unsigned inner;
    goal = rx_byte_q.size() + n;
    while (rx_byte_q.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = MAX_PAYLOAD;
          2, 3:    len = $urandom_range(9, MAX_PAYLOAD - 1);
          default: len = $urandom_range(1, 8);
        endcase
        put_frame(len, 16'($urandom), 1'b1);
      end else if (kind < 70) begin
        put_frame($urandom_range(0, 8), 16'($urandom), 1'b0);
      end else if (kind < 78) begin
        case ($urandom_range(0, 3))
          0:       len = MAX_PAYLOAD + 1;
          1:       len = 32'h0000_FFFF;
          default: len = $urandom_range(MAX_PAYLOAD + 1, 32'h0000_FFFF);
        endcase
        put(start_mk);
        put(len[7:0]);
        put(len[15:8]);
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        put(start_mk);
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
      end else begin
        inner = $urandom_range(0, 4);
        len = inner + stxd_pkg::FRAME_OVERHEAD + $urandom_range(0, 3);
        put(start_mk);
        put(len[7:0]);
        put(len[15:8]);
        put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)));
        put_frame(inner, 16'($urandom), 1'b1);
        repeat (len - inner - stxd_pkg::FRAME_OVERHEAD) put(8'($urandom_range(0, 255)));
        put(end_mk ^ 8'($urandom_range(1, 255)));
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // Sender
  always @(posedge clk) begin
    logic v;
    v = in_valid;
    if (!rst_n) begin
      v = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
        bytes_taken++;
        v = 1'b0;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 17);
      end
      if (!v) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (rx_byte_q.size() > 0) begin
          in_rx_byte <= rx_byte_q.pop_front();
          v = 1'b1;
        end
      end
    end
    in_valid <= v;
  end

  // One long receiver hold-off, counted here
  always @(posedge clk) begin
    if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end else if (long_hold_arm && !long_hold_done) begin
      long_hold_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    delivery_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (delivery_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result expected none actual cmd %h byte %h empty %b last %b",
                   $time, out_command, out_payload_byte, out_empty_frame, out_last_of_frame);
        end else begin
          want = delivery_q.pop_front();
          check_field("command", want.command, out_command);
          check_field("payload_byte", {8'h00, want.payload_byte}, {8'h00, out_payload_byte});
          check_field("empty_frame", {15'h0, want.empty_frame}, {15'h0, out_empty_frame});
          check_field("last_of_frame", {15'h0, want.last_of_frame},
                      {15'h0, out_last_of_frame});
        end
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        rx_gap = rx_calm ? 0 : $urandom_range(0, 17);
      end
      out_ready <= (rx_gap == 0) && (long_hold_left == 0);
      if (rx_gap > 0) rx_gap--;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_START) start_mk = value;
    else end_mk = value;
  endtask

  // Wait until every byte is taken and every delivery has come
  task automatic wait_drained();
    @(negedge clk);
    while (bytes_taken != bytes_queued || delivery_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    put_frame(0, 16'h0000, 1'b1);
    put(8'h00);
    put(8'hFF);
    put(start_mk);
    put(8'd2);
    put(8'd0);
    put(8'hFF);
    put(8'hFF);
    put(8'h00);
    put(8'hFF);
    put(end_mk);
    put_frame(0, 16'h1234, 1'b0);
    put(start_mk);
    put(8'(MAX_PAYLOAD + 1));
    put(8'h00);
    wait_drained();

    reg_write(ADDR_START, 8'h00);
    reg_write(ADDR_END, 8'hFF);
    random_traffic(PHASE_BYTES);
    long_hold_arm <= 1'b1;
    wait_drained();

    reg_write(ADDR_START, 8'hFF);
    reg_write(ADDR_END, 8'h00);
    random_traffic(PHASE_BYTES);
    wait_drained();

    // Same value opens and closes a frame
    reg_write(ADDR_START, 8'h7E);
    reg_write(ADDR_END, 8'h7E);
    random_traffic(PHASE_BYTES);
    wait_drained();

    reg_write(ADDR_START, 8'($urandom_range(0, 255)));
    reg_write(ADDR_END, 8'($urandom_range(0, 255)));
    random_traffic(PHASE_BYTES);
    wait_drained();

    reg_write(ADDR_START, stxd_pkg::START_MARKER_RST);
    reg_write(ADDR_END, stxd_pkg::END_MARKER_RST);
    random_traffic(PHASE_BYTES);
    wait_drained();

    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
